[src/mbps_pkg.sv]
package mbps_pkg;

    localparam int MAX_PATTERN_DEF = 16;   // default window depth
    localparam int PAT_BYTES       = 16;   // bytes held in the two pattern registers
    localparam int BYTE_W          = 8;
    localparam int ADDR_W          = 32;
    localparam int LEN_W           = 5;
    localparam int WILD_W          = 16;
    localparam int SLOT_W          = 4;    // selects one of PAT_BYTES pattern bytes
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int QUEUE_DEPTH     = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WILDCARD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd4;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } t_result;

    // Pick pattern byte idx out of the low/high pattern words.
    function automatic logic [BYTE_W-1:0] pat_byte(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [SLOT_W-1:0]     idx
    );
        logic [2*CFG_DATA_W-1:0] both;
        both = {hi, lo};
        return both[idx*BYTE_W +: BYTE_W];
    endfunction

endpackage

[src/mbps_if.sv]
interface mbps_in_if;
    logic                         valid;
    logic                         ready;
    logic [mbps_pkg::BYTE_W-1:0]  data_byte;
    logic                         last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [mbps_pkg::ADDR_W-1:0]  match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink   (input valid, input found, input match_address, output ready);
endinterface

[src/mbps_cell.sv]
module mbps_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                                i_clk,
    input  logic                                i_shift,
    input  logic [mbps_pkg::BYTE_W-1:0]         i_byte,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     i_pat_lo,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     i_pat_hi,
    input  logic [mbps_pkg::WILD_W-1:0]         i_wild,
    input  logic [mbps_pkg::LEN_W-1:0]          i_len,
    output logic [mbps_pkg::BYTE_W-1:0]         o_byte,
    output logic                                o_hit
);

    localparam logic [mbps_pkg::LEN_W-1:0] IDX = mbps_pkg::LEN_W'(CELL_IDX);

    logic [mbps_pkg::BYTE_W-1:0] r_byte;
    logic [mbps_pkg::LEN_W-1:0]  slot;
    logic                        in_use;
    logic [mbps_pkg::BYTE_W-1:0] pat;

    // This cell holds the byte that sits len-1-IDX places into the candidate.
    assign slot   = i_len - IDX - mbps_pkg::LEN_W'(1);
    assign in_use = IDX < i_len;
    assign pat    = mbps_pkg::pat_byte(i_pat_lo, i_pat_hi, slot[mbps_pkg::SLOT_W-1:0]);

    // Compare against the byte entering this cell on this shift.
    assign o_hit = !in_use || i_wild[slot[mbps_pkg::SLOT_W-1:0]] || (i_byte == pat);

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

[src/mbps_res_q.sv]
module mbps_res_q (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mbps_pkg::t_result i_push_data,
    output logic              o_full,
    mbps_out_if.source        o_res
);

    localparam int PTR_W = $clog2(mbps_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mbps_pkg::QUEUE_DEPTH + 1);

    mbps_pkg::t_result r_q [mbps_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              pop;
    mbps_pkg::t_result head;

    assign pop    = o_res.valid && o_res.ready;
    assign o_full = r_cnt == CNT_W'(mbps_pkg::QUEUE_DEPTH);

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(mbps_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
        end
        if (pop) begin
            n_rp = (r_rp == PTR_W'(mbps_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
        end
        if (i_push && !pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_push_data;
        end
    end

    assign head                = r_q[r_rp];
    assign o_res.valid         = r_cnt != '0;
    assign o_res.found         = head.found;
    assign o_res.match_address = head.match_address;

endmodule

[src/masked_byte_pattern_search.sv]
// A request is compared in the cycle it is accepted; its result goes into the
//   result queue and shows on o_res from its head. Throughput: one request per
//   cycle while the queue has room, set by the cell chain that shifts and compares.
// A two-entry result queue keeps requests flowing while a result waits.
// Reset (i_rst_n low, synchronous): registers to reset values, pattern length
//   to one, byte count and match flag cleared, result queue emptied.
module masked_byte_pattern_search #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    mbps_in_if.sink                             i_req,
    mbps_out_if.source                          o_res
);

    localparam int A_W = mbps_pkg::ADDR_W;
    localparam int L_W = mbps_pkg::LEN_W;

    // Configuration registers
    logic [mbps_pkg::CFG_DATA_W-1:0] r_pat_lo;
    logic [mbps_pkg::CFG_DATA_W-1:0] r_pat_hi;
    logic [mbps_pkg::WILD_W-1:0]     r_wild;
    logic [L_W-1:0]                  r_len;      // held already clamped to 1..MAX_PATTERN
    logic [A_W-1:0]                  r_base;
    logic [L_W-1:0]                  len_wr;

    // Region state
    logic [A_W-1:0]                  r_seen, n_seen;
    logic                            r_done, n_done;

    logic                            accept;
    logic                            q_full;
    logic                            all_hit;
    logic                            hit;
    logic                            push;
    mbps_pkg::t_result               push_data;
    logic [MAX_PATTERN-1:0]          cell_hit;
    logic [mbps_pkg::BYTE_W-1:0]     cell_in  [MAX_PATTERN];
    logic [mbps_pkg::BYTE_W-1:0]     cell_out [MAX_PATTERN];

    // Clamp the written length: zero means one, anything past the window is the window.
    always_comb begin
        len_wr = i_cfg_data[L_W-1:0];
        if (len_wr == '0) begin
            len_wr = L_W'(1);
        end else if (len_wr > L_W'(MAX_PATTERN)) begin
            len_wr = L_W'(MAX_PATTERN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_wild   <= '0;
            r_len    <= L_W'(1);
            r_base   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mbps_pkg::REG_PAT_LO:   r_pat_lo <= i_cfg_data;
                mbps_pkg::REG_PAT_HI:   r_pat_hi <= i_cfg_data;
                mbps_pkg::REG_WILDCARD: r_wild   <= i_cfg_data[mbps_pkg::WILD_W-1:0];
                mbps_pkg::REG_LENGTH:   r_len    <= len_wr;
                mbps_pkg::REG_BASE:     r_base   <= i_cfg_data[A_W-1:0];
                default: ;              // drop writes to unknown indexes
            endcase
        end
    end

    // Take a new request whenever the result queue has room for its result.
    assign i_req.ready = !q_full;
    assign accept      = i_req.valid && i_req.ready;

    // Window: cell 0 takes the new byte, every other cell takes its neighbor's.
    // Each cell checks the byte it is about to hold against its pattern slot.
    genvar g;
    generate
        for (g = 0; g < MAX_PATTERN; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign cell_in[g] = i_req.data_byte;
            end else begin : g_link
                assign cell_in[g] = cell_out[g-1];
            end
            mbps_cell #(
                .CELL_IDX (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_shift  (accept),
                .i_byte   (cell_in[g]),
                .i_pat_lo (r_pat_lo),
                .i_pat_hi (r_pat_hi),
                .i_wild   (r_wild),
                .i_len    (r_len),
                .o_byte   (cell_out[g]),
                .o_hit    (cell_hit[g])
            );
        end
    endgenerate

    assign all_hit = &cell_hit;

    // Count region bytes, saturating at the top of the range.
    assign n_seen = (r_seen == '1) ? r_seen : r_seen + A_W'(1);

    // Report only the first match of a region, only with a nonzero base, and only
    // once the window holds a full pattern's worth of region bytes.
    assign hit = accept && all_hit && !r_done && (r_base != '0)
                 && (n_seen >= A_W'(r_len));

    // Issue a found result on a hit, or a not-found on the final byte of a region that never matched.
    always_comb begin
        push                    = 1'b0;
        push_data.found         = 1'b0;
        push_data.match_address = '0;
        if (hit) begin
            push                    = 1'b1;
            push_data.found         = 1'b1;
            push_data.match_address = r_base + n_seen - A_W'(r_len);
        end else if (accept && i_req.last_byte && !r_done) begin
            push = 1'b1;
        end
    end

    // Clear the region state after its final byte; otherwise advance.
    always_comb begin
        n_done = r_done;
        if (accept) begin
            n_done = r_done || hit;
            if (i_req.last_byte) begin
                n_done = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
            if (accept) begin
                r_seen <= i_req.last_byte ? '0 : n_seen;
            end
        end
    end

    mbps_res_q u_res_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .o_res       (o_res)
    );

endmodule

[tb/masked_byte_pattern_search_tb.sv]
module masked_byte_pattern_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BYTE_W = mbps_pkg::BYTE_W;
    localparam int CFG_IDX_W = mbps_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = mbps_pkg::CFG_DATA_W;
    localparam int WILD_W = mbps_pkg::WILD_W;
    localparam int LEN_W = mbps_pkg::LEN_W;
    localparam int ADDR_W = mbps_pkg::ADDR_W;
    localparam int MAX_PATTERN_DEF = mbps_pkg::MAX_PATTERN_DEF;

    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 12;
    localparam int IDLE_LIMIT = 3000;     // cycles with no handshake before giving up
    localparam int SETTLE_CYCLES = 4;
    localparam int NUM_PHASES = 13;
    localparam int HOLD_PHASE = 4;        // phase that runs with a long receiver hold
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASE_BYTES = 70;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_flag;
    } t_scan_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    mbps_in_if  req_if();
    mbps_out_if res_if();

    masked_byte_pattern_search u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_req      (req_if.sink),
        .o_res      (res_if.source)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow of the block's registers, at their reset values.
    logic [2*CFG_DATA_W-1:0] pat_q = '0;    // {high word, low word}
    logic [WILD_W-1:0]       wild_q = '0;
    logic [LEN_W-1:0]        len_q = LEN_W'(1);
    logic [ADDR_W-1:0]       base_q = '0;

    // Shadow of the scan state of the current region.
    logic [BYTE_W-1:0] window_q [MAX_PATTERN_DEF];   // entry 0 holds the newest byte
    logic [ADDR_W-1:0] seen_q = '0;
    logic              reported_q = 1'b0;

    t_scan_item        byte_feed [$];        // requests waiting for the driver
    mbps_pkg::t_result expected_hits [$];    // results still owed by the block

    int mismatches = 0;
    int bytes_taken = 0;
    int regions_closed = 0;
    int matches_seen = 0;
    int misses_seen = 0;
    int reg_writes = 0;
    int long_holds = 0;
    int idle_cycles = 0;

    // Driver and receiver pacing.
    int burst_left = 0;
    int gap_left = 0;
    int hold_cycles_req = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int stall_phase = 0;
    t_scan_item next_item;

    initial begin
        for (int k = 0; k < MAX_PATTERN_DEF; k++) begin
            window_q[k] = '0;
        end
    end

    // Pattern length as the block applies it: zero counts as one, clamp at the window.
    function automatic int unsigned used_length();
        if (len_q == '0) return 1;
        if (len_q > LEN_W'(MAX_PATTERN_DEF)) return MAX_PATTERN_DEF;
        return 32'(len_q);
    endfunction

    // Shift one accepted byte into the shadow window and queue any result it owes.
    function automatic void advance_scan(input logic [BYTE_W-1:0] b, input logic end_flag);
        int unsigned       len;
        logic              hit;
        mbps_pkg::t_result r;
        len = used_length();
        for (int k = MAX_PATTERN_DEF - 1; k > 0; k--) begin
            window_q[k] = window_q[k-1];
        end
        window_q[0] = b;
        if (seen_q != '1) seen_q++;

        if (!reported_q && base_q != '0 && seen_q >= len) begin
            hit = 1'b1;
            for (int unsigned i = 0; i < len; i++) begin
                if (!wild_q[i] && window_q[len-1-i] != pat_q[i*BYTE_W +: BYTE_W]) hit = 1'b0;
            end
            if (hit) begin
                r.found = 1'b1;
                r.match_address = base_q + (seen_q - ADDR_W'(len));
                expected_hits.insert(expected_hits.size(), r);
                reported_q = 1'b1;
            end
        end

        // Region end: owe a not-found unless a match already went out, then start over.
        if (end_flag) begin
            if (!reported_q) begin
                r = '0;
                expected_hits.insert(expected_hits.size(), r);
            end
            for (int k = 0; k < MAX_PATTERN_DEF; k++) begin
                window_q[k] = '0;
            end
            seen_q = '0;
            reported_q = 1'b0;
            regions_closed++;
        end
    endfunction

    // Driver: bursts of random length with random gaps; hold a request until taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0) begin
                gap_left--;
                req_if.valid <= 1'b0;
            end else if (byte_feed.size() != 0) begin
                next_item = byte_feed.pop_front();
                req_if.valid <= 1'b1;
                req_if.data_byte <= next_item.data_byte;
                req_if.last_byte <= next_item.end_flag;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    // a third of the bursts run straight into the next one
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: a long hold on request, otherwise a stall pattern whose mode is picked
    // anew at random (always ready, coin flip, mostly stalled).
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (hold_cycles_req != 0) begin
                hold_left = hold_cycles_req;
                hold_cycles_req = 0;
                long_holds++;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                if (stall_phase == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    stall_phase = $urandom_range(16, 96);
                end else begin
                    stall_phase--;
                end
                case (stall_mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= 1'($urandom_range(0, 1));
                    default: res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Monitor: predict on every accepted request, check every accepted result,
    // and watch for a stretch with no handshake at all.
    always @(posedge i_clk) begin
        mbps_pkg::t_result want;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                advance_scan(req_if.data_byte, req_if.last_byte);
                bytes_taken++;
            end
            if (res_if.valid && res_if.ready) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result found=%0b match_address=%08h", $time,
                             res_if.found, res_if.match_address);
                    mismatches++;
                end else begin
                    want = expected_hits.pop_front();
                    if (want.found) matches_seen++;
                    else misses_seen++;
                    if (res_if.found !== want.found) begin
                        $display("%0t: found expected %0b actual %0b", $time,
                                 want.found, res_if.found);
                        mismatches++;
                    end
                    if (res_if.match_address !== want.match_address) begin
                        $display("%0t: match_address expected %08h actual %08h", $time,
                                 want.match_address, res_if.match_address);
                        mismatches++;
                    end
                end
            end
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, expected_hits.size());
                $display("[masked_byte_pattern_search] ERROR");
                $finish;
            end
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic end_flag);
        t_scan_item it;
        it.data_byte = b;
        it.end_flag = end_flag;
        byte_feed.insert(byte_feed.size(), it);
    endtask

    // Wait until the block has drained, then give it time to finish internally.
    task automatic settle();
        while (byte_feed.size() != 0 || req_if.valid || expected_hits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drive one register write and mirror it; the block is idle, so apply at once.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        reg_writes++;
        case (idx)
            mbps_pkg::REG_PAT_LO:   pat_q[CFG_DATA_W-1:0] = val;
            mbps_pkg::REG_PAT_HI:   pat_q[2*CFG_DATA_W-1:CFG_DATA_W] = val;
            mbps_pkg::REG_WILDCARD: wild_q = val[WILD_W-1:0];
            mbps_pkg::REG_LENGTH:   len_q = val[LEN_W-1:0];
            mbps_pkg::REG_BASE:     base_q = val[ADDR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Registers with junk above the field, so the block has to mask it off.
    task automatic write_length(input logic [LEN_W-1:0] len);
        logic [CFG_DATA_W-1:0] v;
        v = {$urandom, $urandom};
        v[LEN_W-1:0] = len;
        write_reg(mbps_pkg::REG_LENGTH, v);
    endtask

    task automatic write_mask(input logic [WILD_W-1:0] m);
        logic [CFG_DATA_W-1:0] v;
        v = {$urandom, $urandom};
        v[WILD_W-1:0] = m;
        write_reg(mbps_pkg::REG_WILDCARD, v);
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] a);
        logic [CFG_DATA_W-1:0] v;
        v = {$urandom, $urandom};
        v[ADDR_W-1:0] = a;
        write_reg(mbps_pkg::REG_BASE, v);
    endtask

    task automatic pick_settings();
        logic [LEN_W-1:0]      len_code;
        logic [ADDR_W-1:0]     base_val;
        logic [WILD_W-1:0]     mask_val;
        logic [CFG_DATA_W-1:0] lo_val;
        logic [CFG_DATA_W-1:0] hi_val;
        case ($urandom_range(0, 5))
            0: len_code = '0;
            1: len_code = LEN_W'(1);
            2: len_code = LEN_W'(MAX_PATTERN_DEF);
            3: len_code = LEN_W'($urandom_range(MAX_PATTERN_DEF + 1, 31));
            default: len_code = LEN_W'($urandom_range(2, MAX_PATTERN_DEF - 1));
        endcase
        case ($urandom_range(0, 7))
            0: base_val = '0;
            1: base_val = ADDR_W'(1);
            2: base_val = '1;
            3: base_val = 32'hFFFF_FFF0;
            default: base_val = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: mask_val = '0;
            1: mask_val = '1;
            2: mask_val = WILD_W'($urandom);
            default: mask_val = WILD_W'($urandom & $urandom);
        endcase
        lo_val = {$urandom, $urandom};
        hi_val = {$urandom, $urandom};
        // a narrow alphabet gives many partial matches ahead of the real one
        if ($urandom_range(0, 2) == 0) begin
            lo_val &= 64'h0303_0303_0303_0303;
            hi_val &= 64'h0303_0303_0303_0303;
        end
        write_reg(mbps_pkg::REG_PAT_LO, lo_val);
        write_reg(mbps_pkg::REG_PAT_HI, hi_val);
        write_mask(mask_val);
        write_length(len_code);
        write_base(base_val);
        end_writes();
    endtask

    // Queue one region of n bytes; optionally plant the pattern at a random offset,
    // wildcard positions filled with random bytes. Other bytes are often taken from
    // the pattern itself to make near misses.
    task automatic queue_region(input int unsigned n, input bit plant);
        int unsigned len;
        int unsigned at;
        int unsigned j;
        logic [BYTE_W-1:0] b;
        len = used_length();
        at = (plant && n >= len) ? $urandom_range(0, n - len) : n;
        for (j = 0; j < n; j++) begin
            if (j >= at && j < at + len) begin
                b = wild_q[j-at] ? BYTE_W'($urandom) : pat_q[(j-at)*BYTE_W +: BYTE_W];
            end else if ($urandom_range(0, 1) == 0) begin
                b = pat_q[$urandom_range(0, len - 1)*BYTE_W +: BYTE_W];
            end else begin
                b = BYTE_W'($urandom);
            end
            push_byte(b, j == n - 1);
        end
    endtask

    initial begin
        int unsigned added;
        int unsigned n;
        req_if.valid = 1'b0;
        req_if.data_byte = '0;
        req_if.last_byte = 1'b0;
        res_if.ready = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // Base address still zero from reset: even a matching byte gives not-found.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        settle();

        // Three-byte pattern 00 FF ?? with stray wildcard bits above the length,
        // a base just below the top of the address space, and writes to the spare
        // register indexes, which the block must drop.
        write_reg(mbps_pkg::REG_PAT_LO, 64'h0000_0000_005A_FF00);
        write_reg(mbps_pkg::REG_PAT_HI, {$urandom, $urandom});
        write_mask(16'hFFF4);
        write_length(LEN_W'(3));
        write_base(32'hFFFF_FFFE);
        for (int s = mbps_pkg::REG_BASE + 1; s < 2**CFG_IDX_W; s++) begin
            write_reg(CFG_IDX_W'(s), {$urandom, $urandom});
        end
        end_writes();

        // match that completes on the final byte of the region
        push_byte(8'h11, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h77, 1'b1);
        // early match, a second one later in the region stays silent
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h34, 1'b1);
        // region shorter than the pattern
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        // match address wraps past the top of the address space
        push_byte(8'h22, 1'b0);
        push_byte(8'h22, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h01, 1'b1);
        settle();

        // Length zero acts as one; a one-byte region then matches at the base.
        write_length('0);
        end_writes();
        push_byte(8'h00, 1'b1);
        settle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            pick_settings();
            added = 0;
            if (phase == HOLD_PHASE) begin
                // Hold the receiver off while a stream of tiny regions keeps owing
                // results, so the result queue fills and the input backs up.
                hold_cycles_req = LONG_HOLD_CYCLES;
                while (added < PHASE_BYTES) begin
                    n = $urandom_range(1, 3);
                    queue_region(n, 1'($urandom_range(0, 1)));
                    added += n;
                end
            end else begin
                while (added < PHASE_BYTES) begin
                    if ($urandom_range(0, 7) == 0) n = $urandom_range(1, 40);
                    else n = $urandom_range(1, used_length() + 8);
                    queue_region(n, $urandom_range(0, 4) < 3);
                    added += n;
                end
            end
            // Stop sending until every owed result is in before touching registers.
            settle();
        end

        $display("run covered %0d bytes in %0d regions: %0d matches, %0d not-found",
                 bytes_taken, regions_closed, matches_seen, misses_seen);
        $display("with %0d register writes and %0d long receiver hold(s)",
                 reg_writes, long_holds);
        if (mismatches == 0) begin
            $display("[masked_byte_pattern_search] OK");
        end else begin
            $display("[masked_byte_pattern_search] ERROR");
        end
        $finish;
    end

endmodule

[masked_byte_pattern_search.f]
src/mbps_pkg.sv
src/mbps_if.sv
src/mbps_cell.sv
src/mbps_res_q.sv
src/masked_byte_pattern_search.sv
tb/masked_byte_pattern_search_tb.sv
